[design/drs_pkg.sv]
// Package for the disk request scheduler: sizes, payload words, codes and
// the control and candidate structs shared by the cell row and the top level.
// No dependencies.
`default_nettype none
package drs_pkg;

  localparam int MAX_REQ = 32;
  localparam int IDX_W   = $clog2(MAX_REQ);
  localparam int CNT_W   = $clog2(MAX_REQ + 1);
  localparam int REM_W   = $clog2(MAX_REQ + 3);
  localparam int CYL_W   = 16;
  localparam int TRV_W   = 22;
  localparam int KEY_W   = CYL_W + IDX_W;

  // Register index taken from paddr[2]
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_CYLCNT = 1'b1;

  localparam logic [CYL_W-1:0] CYLCNT_RESET = 16'd5000;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SSTF  = 2'd1,
    POL_CSCAN = 2'd2,
    POL_LOOK  = 2'd3
  } policy_t;

  // Selection rule applied by every cell during a scan
  typedef enum logic [2:0] {
    M_FCFS,
    M_SSTF,
    M_UP,
    M_LOW,
    M_DOWN
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             last;
  } req_t;

  typedef struct packed {
    logic [CYL_W-1:0] served_cylinder;
    logic [TRV_W-1:0] travel_so_far;
    logic             final_res;
    logic             overflowed;
    logic             none_served;
  } res_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    mode_t            mode;
    logic [CYL_W-1:0] start;
    logic [CYL_W-1:0] cur;
    logic [CNT_W-1:0] count;
    logic             clear;
    logic             mark;
    logic [IDX_W-1:0] mark_idx;
  } ctl_t;

  // Best candidate handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic [CYL_W-1:0] cyl;
  } best_t;

endpackage
`default_nettype wire

[design/drs_req_if.sv]
// Request channel: valid/ready handshake carrying one request word.
// Depends on drs_pkg.
`default_nettype none
interface drs_req_if;
  import drs_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/drs_res_if.sv]
// Result channel: valid/ready handshake carrying one visit word.
// Depends on drs_pkg.
`default_nettype none
interface drs_res_if;
  import drs_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/drs_cell.sv]
// One cell of the request row: holds a request and its served mark and
// forwards the best pending candidate seen so far to its neighbor.
// Depends on drs_pkg.
`default_nettype none
module drs_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [drs_pkg::IDX_W-1:0] cell_idx,
  input  wire logic                      load,
  input  wire logic [drs_pkg::CYL_W-1:0] load_cyl,
  input  wire drs_pkg::ctl_t             ctl,
  input  wire drs_pkg::best_t            best_in,
  output drs_pkg::best_t                 best_out
);
  import drs_pkg::*;

  logic [CYL_W-1:0] cyl_r;
  logic             served_r;
  best_t            best_r;

  logic             valid;
  logic             elig;
  logic [CYL_W-1:0] span;
  logic [KEY_W-1:0] own_key;
  best_t            best_nxt;

  // Hold the request
  always_ff @(posedge clk) begin
    if (load) begin
      cyl_r <= load_cyl;
    end
  end

  // Set on selection, drop at batch end
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      served_r <= 1'b0;
    end else if (ctl.mark && ctl.mark_idx == cell_idx) begin
      served_r <= 1'b1;
    end
  end

  // Key and eligibility under the current rule
  always_comb begin
    valid = CNT_W'(cell_idx) < ctl.count;
    span  = (cyl_r >= ctl.cur) ? cyl_r - ctl.cur : ctl.cur - cyl_r;
    elig  = valid && !served_r;
    case (ctl.mode)
      M_FCFS: own_key = {{CYL_W{1'b0}}, cell_idx};
      M_SSTF: own_key = {span, cell_idx};
      M_UP: begin
        own_key = {cyl_r, cell_idx};
        elig    = elig && (cyl_r >= ctl.start);
      end
      M_LOW: begin
        own_key = {cyl_r, cell_idx};
        elig    = elig && (cyl_r < ctl.start);
      end
      M_DOWN: begin
        own_key = {~cyl_r, ~cell_idx};
        elig    = elig && (cyl_r < ctl.start);
      end
      default: begin
        own_key = {cyl_r, cell_idx};
        elig    = 1'b0;
      end
    endcase
    best_nxt = best_in;
    if (elig && (!best_in.found || own_key < best_in.key)) begin
      best_nxt.found = 1'b1;
      best_nxt.key   = own_key;
      best_nxt.idx   = cell_idx;
      best_nxt.cyl   = cyl_r;
    end
  end

  // Advance the candidate one cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else begin
      best_r <= best_nxt;
    end
  end

  assign best_out = best_r;

endmodule
`default_nettype wire

[design/disk_request_scheduler_unit.sv]
// Disk request scheduler top level: configuration registers, batch
// sequencer and the row of request cells. Depends on drs_pkg, drs_req_if,
// drs_res_if and drs_cell.
//
// Usage: requests arrive as words on in_ch, one per cycle while the block
// is loading; the word with last set closes the batch. Requests at or above
// cylinder_count are dropped; past 32 stored requests, legal ones are
// dropped and overflowed is raised on every visit word. After the closing
// word in_ch.ready falls and the block emits one word per visit on out_ch.
// Each visit is picked by a candidate that travels the 32-cell row. The
// C-SCAN top stop follows a row pass that finds nothing above the head,
// and the zero stop is issued as soon as the top stop word is taken; LOOK
// spends one extra empty row pass where it turns downward. An empty batch
// yields one word with none_served set. When out_ch.ready is low the
// current word holds and the walk waits. Reset (rst_n low, synchronous)
// empties the batch, sets policy to FCFS and cylinder_count to 5000.
// Registers: policy at byte 0, cylinder_count at byte 4; write them only
// while no batch is in progress.
`default_nettype none
module disk_request_scheduler_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  drs_req_if.sink          in_ch,
  drs_res_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import drs_pkg::*;

  policy_t          policy_r;
  logic [CYL_W-1:0] cylcnt_r;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  policy_t          pol_r, pol_nxt;
  mode_t            mode_r, mode_nxt;
  logic [CYL_W-1:0] start_r, start_nxt;
  logic [CYL_W-1:0] cur_r, cur_nxt;
  logic [TRV_W-1:0] travel_r, travel_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             first_r, first_nxt;
  logic             zpend_r, zpend_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             oval_r, oval_nxt;
  res_t             odata_r, odata_nxt;

  logic             load;
  logic             clear;
  logic             mark;
  logic             do_visit;
  logic [CYL_W-1:0] visit_cyl;
  logic [CYL_W-1:0] step;
  logic [CNT_W-1:0] n_after;
  ctl_t             ctl;
  best_t            chain [MAX_REQ+1];
  best_t            winner;
  logic             cfg_wr;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FCFS;
      cylcnt_r <= CYLCNT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_POLICY: policy_r <= policy_t'(cfg_pwdata[1:0]);
        REG_CYLCNT: cylcnt_r <= cfg_pwdata[CYL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_POLICY: cfg_prdata = {30'd0, policy_r};
      REG_CYLCNT: cfg_prdata = {16'd0, cylcnt_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // Cell row
  assign chain[0] = '0;
  assign winner   = chain[MAX_REQ];

  always_comb begin
    ctl.mode     = mode_r;
    ctl.start    = start_r;
    ctl.cur      = cur_r;
    ctl.count    = count_r;
    ctl.clear    = clear;
    ctl.mark     = mark;
    ctl.mark_idx = winner.idx;
  end

  for (genvar g = 0; g < MAX_REQ; g++) begin : g_cell
    drs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .load     (load && count_r == CNT_W'(g)),
      .load_cyl (in_ch.data.cylinder),
      .ctl      (ctl),
      .best_in  (chain[g]),
      .best_out (chain[g+1])
    );
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      pol_r   <= POL_FCFS;
      mode_r  <= M_FCFS;
      rem_r   <= '0;
      first_r <= 1'b0;
      zpend_r <= 1'b0;
      scan_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      pol_r   <= pol_nxt;
      mode_r  <= mode_nxt;
      rem_r   <= rem_nxt;
      first_r <= first_nxt;
      zpend_r <= zpend_nxt;
      scan_r  <= scan_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    cur_r    <= cur_nxt;
    travel_r <= travel_nxt;
    odata_r  <= odata_nxt;
  end

  // Next state: load, scan the row, emit visits
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    pol_nxt    = pol_r;
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    cur_nxt    = cur_r;
    travel_nxt = travel_r;
    rem_nxt    = rem_r;
    first_nxt  = first_r;
    zpend_nxt  = zpend_r;
    scan_nxt   = scan_r;
    oval_nxt   = oval_r;
    odata_nxt  = odata_r;
    load       = 1'b0;
    clear      = 1'b0;
    mark       = 1'b0;
    do_visit   = 1'b0;
    visit_cyl  = '0;
    n_after    = count_r;
    in_ch.ready = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.data.cylinder < cylcnt_r) begin
            if (count_r < CNT_W'(MAX_REQ)) begin
              load    = 1'b1;
              n_after = count_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          count_nxt = n_after;
          if (in_ch.data.last) begin
            if (n_after == '0) begin
              oval_nxt              = 1'b1;
              odata_nxt             = '0;
              odata_nxt.none_served = 1'b1;
              rem_nxt               = '0;
              state_nxt             = ST_EMIT;
            end else begin
              pol_nxt   = policy_r;
              mode_nxt  = M_FCFS;
              first_nxt = 1'b1;
              rem_nxt   = REM_W'(n_after) + ((policy_r == POL_CSCAN) ? REM_W'(2) : '0);
              scan_nxt  = '0;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        scan_nxt = scan_r + 1'b1;
        if (scan_r == CNT_W'(MAX_REQ)) begin
          if (winner.found) begin
            do_visit  = 1'b1;
            visit_cyl = winner.cyl;
            mark      = 1'b1;
            if (first_r) begin
              start_nxt = winner.cyl;
              case (pol_r)
                POL_FCFS: mode_nxt = M_FCFS;
                POL_SSTF: mode_nxt = M_SSTF;
                default:  mode_nxt = M_UP;
              endcase
            end
            state_nxt = ST_EMIT;
          end else if (pol_r == POL_CSCAN) begin
            do_visit  = 1'b1;
            visit_cyl = cylcnt_r - 1'b1;
            zpend_nxt = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            mode_nxt = M_DOWN;
            scan_nxt = '0;
          end
        end
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          oval_nxt = 1'b0;
          if (rem_r == '0) begin
            clear     = 1'b1;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else if (zpend_r) begin
            do_visit  = 1'b1;
            visit_cyl = '0;
            zpend_nxt = 1'b0;
            mode_nxt  = M_LOW;
          end else begin
            scan_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Build a visit word and advance the head
    step = (visit_cyl >= cur_r) ? visit_cyl - cur_r : cur_r - visit_cyl;
    if (do_visit) begin
      oval_nxt                  = 1'b1;
      odata_nxt.served_cylinder = visit_cyl;
      travel_nxt                = first_r ? '0 : travel_r + TRV_W'(step);
      odata_nxt.travel_so_far   = travel_nxt;
      odata_nxt.final_res       = (rem_r == REM_W'(1));
      odata_nxt.overflowed      = ovf_r;
      odata_nxt.none_served     = 1'b0;
      cur_nxt                   = visit_cyl;
      rem_nxt                   = rem_r - 1'b1;
      first_nxt                 = 1'b0;
    end
  end

  assign out_ch.valid = oval_r;
  assign out_ch.data  = odata_r;

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REQ))
    else $error("request count past store size");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.none_served |->
      out_ch.data.served_cylinder == '0 && out_ch.data.travel_so_far == '0 &&
      !out_ch.data.final_res)
    else $error("empty batch word carries data");

  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.data.final_res |=> state_r == ST_IDLE)
    else $error("walk continues after final visit");

  a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !oval_r)
    else $error("result pending while loading");

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for disk_request_scheduler_unit: random and directed
// request batches under all four seek policies, checked visit by visit.
// Depends on drs_pkg, drs_req_if, drs_res_if and the scheduler RTL.
`default_nettype none
module testbench;
  import drs_pkg::*;

  localparam logic [2:0] ADDR_POLICY = 3'd0;
  localparam logic [2:0] ADDR_CYLCNT = 3'd4;
  localparam int         STORE_DEPTH = 32;
  localparam int         STALL_LIMIT = 20000;
  localparam int         DRAIN_WAIT  = 60;

  // Tracks the pending batch and the visit words it must produce
  class seek_board;
    policy_t     pol;
    int          ncyl;
    int          reqs[STORE_DEPTH];
    int          nreq;
    bit          ovf;
    res_t        visit_q[$];
    int          errs;

    function new();
      pol  = POL_FCFS;
      ncyl = 5000;
      nreq = 0;
      ovf  = 0;
      errs = 0;
    endfunction

    function int gap(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Store one accepted request word; on the closing word queue the visits
    function void note_request(req_t r);
      int   path[$];
      int   keys[STORE_DEPTH];
      bit   done[STORE_DEPTH];
      int   i, j, k, s, cur, best, bd, d, travel;
      res_t w;
      if (r.cylinder < ncyl) begin
        if (nreq < STORE_DEPTH) begin
          reqs[nreq] = r.cylinder;
          nreq++;
        end else begin
          ovf = 1;
        end
      end
      if (!r.last) return;
      if (nreq == 0) begin
        w = '0;
        w.none_served = 1'b1;
        visit_q.push_back(w);
        ovf = 0;
        return;
      end
      // Stable order by cylinder, arrival index in the low bits
      for (i = 0; i < nreq; i++) begin
        k = reqs[i] * 64 + i;
        j = i;
        while (j > 0 && keys[j-1] > k) begin
          keys[j] = keys[j-1];
          j--;
        end
        keys[j] = k;
      end
      s = 0;
      for (i = 0; i < nreq; i++)
        if (keys[i] % 64 == 0) s = i;
      case (pol)
        POL_FCFS: begin
          for (i = 0; i < nreq; i++) path.push_back(reqs[i]);
        end
        POL_SSTF: begin
          for (i = 0; i < nreq; i++) done[i] = 0;
          done[0] = 1;
          cur = reqs[0];
          path.push_back(cur);
          for (k = 1; k < nreq; k++) begin
            best = -1;
            bd = 0;
            for (i = 0; i < nreq; i++) begin
              if (done[i]) continue;
              d = gap(reqs[i], cur);
              if (best < 0 || d < bd) begin
                best = i;
                bd = d;
              end
            end
            done[best] = 1;
            cur = reqs[best];
            path.push_back(cur);
          end
        end
        POL_CSCAN: begin
          for (i = s; i < nreq; i++) path.push_back(keys[i] / 64);
          path.push_back(ncyl - 1);
          path.push_back(0);
          for (i = 0; i < s; i++) path.push_back(keys[i] / 64);
        end
        default: begin
          for (i = s; i < nreq; i++) path.push_back(keys[i] / 64);
          for (i = s - 1; i >= 0; i--) path.push_back(keys[i] / 64);
        end
      endcase
      travel = 0;
      for (i = 0; i < path.size(); i++) begin
        if (i != 0) travel += gap(path[i], path[i-1]);
        w.served_cylinder = path[i][CYL_W-1:0];
        w.travel_so_far   = travel[TRV_W-1:0];
        w.final_res       = (i == path.size() - 1);
        w.overflowed      = ovf;
        w.none_served     = 1'b0;
        visit_q.push_back(w);
      end
      nreq = 0;
      ovf = 0;
    endfunction

    // Compare one visit word against the oldest expectation
    function void check_visit(res_t got);
      res_t want;
      if (visit_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected visit word %p", got);
        return;
      end
      want = visit_q.pop_front();
      if (got !== want) begin
        errs++;
        if (errs <= 10) $display("visit mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  bit          idle_on;
  int          quiet;
  int          sent;
  seek_board   board;

  drs_req_if in_ch ();
  drs_res_if out_ch ();

  disk_request_scheduler_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Random backpressure on the visit channel
  always @(posedge clk) begin
    out_ch.ready <= idle_on ? ($urandom_range(99) >= 7) : 1'b1;
  end

  // Check visit words and watch for a stalled run
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_visit(out_ch.data);
    if (!rst_n || (out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_POLICY) board.pol = policy_t'(val[1:0]);
    else board.ncyl = val[15:0];
  endtask

  // Hold until every visit has arrived, then let the block settle
  task automatic settle();
    while (board.visit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_mode(input policy_t p, input int ncyl);
    cfg_write(ADDR_POLICY, 32'(p));
    cfg_write(ADDR_CYLCNT, 32'(ncyl));
  endtask

  // Send one batch, the final word marked last
  task automatic run_batch(input int cyls[$]);
    req_t r;
    for (int i = 0; i < cyls.size(); i++) begin
      while (idle_on && $urandom_range(99) < 7) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      r.cylinder = cyls[i][15:0];
      r.last     = (i == cyls.size() - 1);
      in_ch.valid <= 1'b1;
      in_ch.data  <= r;
      do @(posedge clk); while (!in_ch.ready);
      board.note_request(r);
      sent++;
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    int   batch[$];
    int   len, ncyl, sel;
    board = new();
    sent = 0;
    idle_on = 1;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, extremes, ties, duplicates, empty batch
    batch = '{4999, 0, 5000, 65535, 17};
    run_batch(batch);
    settle();
    set_mode(POL_FCFS, 65535);
    batch = '{65534, 0, 65535, 100};
    run_batch(batch);
    settle();
    set_mode(POL_SSTF, 5000);
    batch = '{50, 40, 60, 45};
    run_batch(batch);
    settle();
    set_mode(POL_CSCAN, 1);
    batch = '{0, 5, 0};
    run_batch(batch);
    settle();
    set_mode(POL_LOOK, 5000);
    batch = '{300, 100, 4999, 300, 200};
    run_batch(batch);
    settle();
    batch = '{7000};
    run_batch(batch);
    settle();
    set_mode(POL_CSCAN, 200);
    batch = '{120, 10, 199, 120};
    run_batch(batch);
    settle();

    // Random batches; mostly short, a few past the store size
    while (sent < 480) begin
      idle_on = !(sent > 200 && sent < 300);
      sel = $urandom_range(5);
      case (sel)
        0: ncyl = 1;
        1: ncyl = 65535;
        2: ncyl = $urandom_range(64, 2);
        default: ncyl = $urandom_range(65535, 1);
      endcase
      set_mode(policy_t'($urandom_range(3)), ncyl);
      len = ($urandom_range(99) < 8) ? $urandom_range(40, 33) : $urandom_range(8, 1);
      batch.delete();
      for (int i = 0; i < len; i++)
        batch.push_back(($urandom_range(99) < 85) ? $urandom_range(ncyl - 1, 0)
                                                   : $urandom_range(65535, 0));
      run_batch(batch);
      settle();
    end

    if (board.errs == 0 && board.visit_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
